// File: hw/rtl/packet_body_xor_checksum_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packet body XOR checksum block
// Shared concurrent-assertion forms used by the RTL modules.
// ---------------------------------------------------------------------------
`ifndef PACKET_BODY_XOR_CHECKSUM_TOP_MACROS_SVH
`define PACKET_BODY_XOR_CHECKSUM_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PBXC_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbxc assertion failed");

// Next-cycle implication, disabled during reset.
`define PBXC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbxc assertion failed");

`endif

// File: hw/rtl/pbxc_pkg.sv
// ---------------------------------------------------------------------------
// pbxc_pkg
// Types and constants shared by the packet body XOR checksum modules.
// ---------------------------------------------------------------------------
package pbxc_pkg;

   localparam int LENGTH_BITS = 16;
   localparam logic [63:0] MIX_MASK = 64'h0000_0000_0000_0FFD;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [LENGTH_BITS-1:0] len_type;

   typedef enum logic [1:0] {
      KIND_EMPTY,
      KIND_GROUP,
      KIND_TAIL
   } kind_type;

   typedef struct packed {
      logic               func;
      logic [7:0]         data_in;
      logic [15:0]        body_length;
      logic signed [63:0] key;
      logic signed [63:0] verify_sum;
   } req_type;

   typedef struct packed {
      logic [7:0]         data_out;
      logic               data_valid;
      logic               last;
      logic signed [63:0] checksum;
      logic               check_ok;
   } rsp_type;

   // One classified byte handed from the front end to the back end.
   typedef struct packed {
      kind_type           kind;
      logic               first;
      logic               last;
      logic [2:0]         lane;
      logic [7:0]         data_out;
      logic [7:0]         plain;
      logic               dir;
      logic signed [63:0] key;
      logic signed [63:0] expected;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage

// File: hw/rtl/pbxc_front.sv
// ---------------------------------------------------------------------------
// pbxc_front
// Accepts body bytes, tracks packet position, applies the key XOR and
// classifies each byte as empty packet, full-group byte or tail byte.
// ---------------------------------------------------------------------------
`include "packet_body_xor_checksum_top_macros.svh"

module pbxc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbxc_pkg::req_type req_data,
   input  pbxc_pkg::qstat_type qstat,
   output logic              push_valid,
   output pbxc_pkg::cmd_type push_cmd
);
   import pbxc_pkg::*;

   len_type            pos_ff, pos_in;
   len_type            plen_ff, plen_in;
   logic               dir_ff, dir_in;
   logic signed [63:0] key_ff, key_in;
   logic signed [63:0] exp_ff, exp_in;

   logic               accept;
   logic               first;
   len_type            plen_cur;
   len_type            full_end;
   len_type            pos_next;
   logic               dir_cur;
   logic signed [63:0] key_cur;
   logic signed [63:0] exp_cur;
   logic [2:0]         lane;
   logic [7:0]         key_byte;
   logic [7:0]         outb;
   logic               is_empty;
   logic               is_last;

   always_comb begin
      accept    = req_valid && !qstat.full;
      req_stall = qstat.full;

      first    = (pos_ff == '0);
      plen_cur = first ? LENGTH_BITS'(req_data.body_length) : plen_ff;
      dir_cur  = first ? req_data.func : dir_ff;
      key_cur  = first ? req_data.key : key_ff;
      exp_cur  = first ? req_data.verify_sum : exp_ff;

      lane     = pos_ff[2:0];
      key_byte = key_cur[{lane, 3'b000} +: 8];
      outb     = req_data.data_in ^ key_byte;
      full_end = plen_cur & ~LENGTH_BITS'(7);
      pos_next = pos_ff + LENGTH_BITS'(1);
      is_empty = first && (plen_cur == '0);
      is_last  = is_empty || (pos_next >= plen_cur) || (pos_next == '0);

      push_valid        = accept;
      push_cmd.first    = first;
      push_cmd.last     = is_last;
      push_cmd.lane     = lane;
      push_cmd.data_out = is_empty ? 8'h00 : outb;
      push_cmd.plain    = dir_cur ? outb : req_data.data_in;
      push_cmd.dir      = dir_cur;
      push_cmd.key      = key_cur;
      push_cmd.expected = exp_cur;
      priority if (is_empty) begin
         push_cmd.kind = KIND_EMPTY;
      end else if (pos_ff < full_end) begin
         push_cmd.kind = KIND_GROUP;
      end else begin
         push_cmd.kind = KIND_TAIL;
      end

      pos_in  = pos_ff;
      plen_in = plen_ff;
      dir_in  = dir_ff;
      key_in  = key_ff;
      exp_in  = exp_ff;
      if (accept) begin
         plen_in = plen_cur;
         dir_in  = dir_cur;
         key_in  = key_cur;
         exp_in  = exp_cur;
         // return to packet start after the last byte
         pos_in  = is_last ? '0 : pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         plen_ff <= '0;
         dir_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         plen_ff <= plen_in;
         dir_ff  <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      exp_ff <= exp_in;
   end

   `PBXC_ASSERT(a_pos_inside_packet, clock, reset, pos_ff != '0, pos_ff < plen_ff)
   `PBXC_ASSERT(a_push_only_with_room, clock, reset, push_valid, !qstat.full)

endmodule

// File: hw/rtl/pbxc_queue.sv
// ---------------------------------------------------------------------------
// pbxc_queue
// Short register queue of classified bytes between front and back end.
// ---------------------------------------------------------------------------
`include "packet_body_xor_checksum_top_macros.svh"

module pbxc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  pbxc_pkg::cmd_type   push_cmd,
   input  logic                pop,
   output pbxc_pkg::cmd_type   pop_cmd,
   output pbxc_pkg::qstat_type qstat
);
   import pbxc_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   always_comb begin
      qstat.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      qstat.not_empty = (count_ff != '0);
      do_push         = push_valid && !qstat.full;
      do_pop          = pop && qstat.not_empty;
      pop_cmd         = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PBXC_ASSERT(a_count_bounded, clock, reset, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `PBXC_ASSERT_NEXT(a_fills_up, clock, reset,
      do_push && !do_pop && count_ff == QUEUE_CNT_W'(QUEUE_DEPTH - 1), qstat.full)

endmodule

// File: hw/rtl/pbxc_back.sv
// ---------------------------------------------------------------------------
// pbxc_back
// Folds classified bytes into the running checksum and registers results.
// ---------------------------------------------------------------------------
`include "packet_body_xor_checksum_top_macros.svh"

module pbxc_back (
   input  logic              clock,
   input  logic              reset,
   input  pbxc_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbxc_pkg::rsp_type rsp_data
);
   import pbxc_pkg::*;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic signed [63:0] sum_ff, sum_in;
   logic [55:0]        gather_ff, gather_in;
   logic [63:0]        mix_ff, mix_in;

   logic               out_ready;
   logic signed [63:0] sum_base;
   logic [55:0]        gather_base;
   logic [63:0]        mix_base;
   logic signed [63:0] sum_new;
   logic [55:0]        gather_new;
   logic [63:0]        mix_new;

   always_comb begin
      out_ready = !rsp_valid_ff || !rsp_stall;
      pop       = cmd_valid && out_ready;

      // start every packet from a clean checksum
      sum_base    = cmd.first ? '0 : sum_ff;
      gather_base = cmd.first ? '0 : gather_ff;
      mix_base    = cmd.first ? '0 : mix_ff;

      sum_new    = sum_base;
      gather_new = gather_base;
      mix_new    = mix_base;
      unique case (cmd.kind)
         KIND_EMPTY: begin
            sum_new = '0;
         end
         KIND_GROUP: begin
            if (cmd.lane == 3'd7) begin
               sum_new    = sum_base ^ {cmd.plain, gather_base};
               gather_new = '0;
            end else begin
               for (int i = 0; i < 7; i++) begin
                  if (cmd.lane == 3'(i)) begin
                     gather_new[i*8 +: 8] = gather_base[i*8 +: 8] | cmd.plain;
                  end
               end
            end
         end
         KIND_TAIL: begin
            mix_new = ((mix_base >> 4) & MIX_MASK) ^ cmd.key;
            sum_new = (sum_base ^ {56'd0, cmd.plain}) + mix_new;
         end
         default: begin
            sum_new = sum_base;
         end
      endcase

      rsp_data_in.data_out   = cmd.data_out;
      rsp_data_in.data_valid = (cmd.kind != KIND_EMPTY);
      rsp_data_in.last       = cmd.last;
      rsp_data_in.checksum   = cmd.last ? sum_new : '0;
      rsp_data_in.check_ok   = cmd.last && cmd.dir && (sum_new == cmd.expected);

      sum_in    = pop ? sum_new : sum_ff;
      gather_in = pop ? gather_new : gather_ff;
      mix_in    = pop ? mix_new : mix_ff;

      priority if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         gather_ff    <= '0;
         mix_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         gather_ff    <= gather_in;
         mix_ff       <= mix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `PBXC_ASSERT(a_ok_only_on_last, clock, reset, rsp_valid_ff && rsp_data_ff.check_ok,
      rsp_data_ff.last)
   `PBXC_ASSERT(a_empty_is_last, clock, reset, rsp_valid_ff && !rsp_data_ff.data_valid,
      rsp_data_ff.last && rsp_data_ff.checksum == '0)

endmodule

// File: hw/rtl/packet_body_xor_checksum_top.sv
// ---------------------------------------------------------------------------
// packet_body_xor_checksum_top
// Streaming packet body cipher with 64-bit checksum and verify.
// ---------------------------------------------------------------------------
// One body byte is accepted per clock and one result item leaves per clock
// in steady state while rsp_stall stays low; each byte is registered in the
// queue and then in the back end's result register before its rsp_valid
// rises. That rate is set by the back end's combinational checksum update
// (byte XOR, plus mix update and 64-bit add on tail bytes). The first byte
// of a packet latches func, body_length, key and verify_sum; the other
// bytes ignore those fields. A packet with body_length zero takes one item
// and gives one result with data_valid low, last high and checksum zero. A
// two-entry queue sits between front and back end; in a steady stream one
// entry is in use, so req_ takes one more item after rsp_ stalls (two when
// starting from idle) before req_stall rises.
// ---------------------------------------------------------------------------
module packet_body_xor_checksum_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbxc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbxc_pkg::rsp_type rsp_data
);
   import pbxc_pkg::*;

   qstat_type qstat;
   logic      push_valid;
   cmd_type   push_cmd;
   cmd_type   pop_cmd;
   logic      pop;

   pbxc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   pbxc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .pop_cmd    (pop_cmd),
      .qstat      (qstat)
   );

   pbxc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (pop_cmd),
      .cmd_valid (qstat.not_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench for packet_body_xor_checksum_top
// Drives whole packets of body bytes, in both directions, through the
// streaming cipher with random gaps and stalls. A bit-accurate predictor of
// the key XOR, group/tail checksum and verify flag builds the result owed for
// every accepted byte. Each result is checked field by field in order.
// ---------------------------------------------------------------------------
module testbench;
   import pbxc_pkg::*;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;
   localparam int   RANDOM_ITEMS = 1040;
   localparam int   LONG_BODY    = 256;

   // Predicts the cipher output and checksum byte by byte, holds the owed
   // results in order and checks the block's results against them.
   class body_cipher_board;
      logic [15:0] position = '0;
      logic [15:0] span = '0;
      logic [63:0] pkt_key = '0;
      logic [63:0] want_sum = '0;
      logic        decrypt = 1'b0;
      logic [63:0] gather = '0;
      logic [63:0] sum = '0;
      logic [63:0] mix = '0;
      rsp_type     owed[$];
      int          errors = 0;

      function rsp_type cipher_byte(req_type r);
         rsp_type     o;
         logic [5:0]  shift;
         logic [7:0]  outb;
         logic [7:0]  plain;
         logic [15:0] full_end;
         o = '0;
         if (position == 0) begin
            decrypt  = r.func;
            span     = r.body_length;
            pkt_key  = r.key;
            want_sum = r.verify_sum;
            gather   = '0;
            sum      = '0;
            mix      = '0;
            if (span == 0) begin
               o.last     = 1'b1;
               o.check_ok = decrypt && (want_sum == 64'd0);
               return o;
            end
         end
         shift    = {position[2:0], 3'b000};
         outb     = r.data_in ^ pkt_key[shift +: 8];
         plain    = decrypt ? outb : r.data_in;
         full_end = {span[15:3], 3'b000};
         if (position < full_end) begin
            // full group: gather seven bytes, fold the word on the eighth
            if (position[2:0] == 3'd7) begin
               sum    = sum ^ (gather | {plain, 56'd0});
               gather = '0;
            end else begin
               gather = gather | ({56'd0, plain} << shift);
            end
         end else begin
            sum = sum ^ {56'd0, plain};
            mix = ((mix >> 4) & MIX_MASK) ^ pkt_key;
            sum = sum + mix;
         end
         position     = position + 16'd1;
         o.data_out   = outb;
         o.data_valid = 1'b1;
         if (position >= span || position == 0) begin
            o.last     = 1'b1;
            o.checksum = sum;
            o.check_ok = decrypt && (sum == want_sum);
            position   = '0;
         end
         return o;
      endfunction

      function void note_req(req_type r);
         owed.push_back(cipher_byte(r));
      endfunction

      function int pending();
         return owed.size();
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_rsp(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report($sformatf("result with nothing owed: %h", got));
            return;
         end
         want = owed.pop_front();
         if (got.data_out !== want.data_out)
            report($sformatf("data_out %h, want %h", got.data_out, want.data_out));
         if (got.data_valid !== want.data_valid)
            report($sformatf("data_valid %b, want %b", got.data_valid, want.data_valid));
         if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
         if (got.checksum !== want.checksum)
            report($sformatf("checksum %h, want %h", got.checksum, want.checksum));
         if (got.check_ok !== want.check_ok)
            report($sformatf("check_ok %b, want %b", got.check_ok, want.check_ok));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   body_cipher_board board = new();
   int  items_sent = 0;
   bit  calm = 1'b0;
   int  stall_left = 0;

   packet_body_xor_checksum_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("packet_body_xor_checksum_top verification failed");
      $finish;
   end

   // Mostly short gaps, now and then a long one, none while calm.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60)
         return 0;
      else if (roll < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   task automatic push_byte(req_type r);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.note_req(r);
      items_sent++;
   endtask

   // Send one packet; fill >= 0 forces every body byte to that value. With
   // match set, the expected checksum is made to equal the real one.
   task automatic send_packet(logic dir, logic [15:0] len, logic [63:0] pkt_key,
                              logic [63:0] check, bit match, int fill);
      req_type          items[$];
      req_type          r;
      rsp_type          got;
      body_cipher_board trial;
      int               count;
      count = (len == 0) ? 1 : len;
      for (int i = 0; i < count; i++) begin
         // later bytes carry noise in the header fields, which must be ignored
         r.func        = 1'($urandom_range(0, 1));
         r.data_in     = (fill >= 0) ? fill[7:0] : 8'($urandom_range(0, 255));
         r.body_length = 16'($urandom_range(0, 65535));
         r.key         = {$urandom, $urandom};
         r.verify_sum  = {$urandom, $urandom};
         if (i == 0) begin
            r.func        = dir;
            r.body_length = len;
            r.key         = pkt_key;
            r.verify_sum  = check;
         end
         items.push_back(r);
      end
      if (match) begin
         trial = new();
         foreach (items[i]) got = trial.cipher_byte(items[i]);
         items[0].verify_sum = got.checksum;
      end
      foreach (items[i]) push_byte(items[i]);
   endtask

   function automatic logic [63:0] pick_key();
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7FFF_FFFF_FFFF_FFFF;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // result side: sample at the rising edge, change stall at the falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_rsp(rsp_data);
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      logic        dir;
      logic [15:0] len;
      int          roll;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty packets in both directions, verify against zero and nonzero
      send_packet(FUNC_ENCRYPT, 16'd0, 64'h0123_4567_89AB_CDEF, '1, 1'b0, -1);
      send_packet(FUNC_DECRYPT, 16'd0, 64'h0123_4567_89AB_CDEF, 64'd0, 1'b0, -1);
      send_packet(FUNC_DECRYPT, 16'd0, '1, 64'd1, 1'b0, -1);
      // single tail byte, one full group, group plus tail, short tail
      send_packet(FUNC_ENCRYPT, 16'd1, '1, 64'd0, 1'b0, 8'hFF);
      send_packet(FUNC_DECRYPT, 16'd8, 64'h8000_0000_0000_0000, 64'd0, 1'b1, 8'h00);
      send_packet(FUNC_DECRYPT, 16'd9, 64'h7FFF_FFFF_FFFF_FFFF, '1, 1'b0, -1);
      send_packet(FUNC_ENCRYPT, 16'd3, 64'd0, 64'h8000_0000_0000_0000, 1'b0, -1);

      while (items_sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 99) < 15);
         dir  = 1'($urandom_range(0, 1));
         roll = $urandom_range(0, 99);
         if (roll < 10)
            len = 16'd0;
         else if (roll < 60)
            len = 16'($urandom_range(1, 16));
         else if (roll < 90)
            len = 16'($urandom_range(17, 40));
         else
            len = 16'($urandom_range(41, 100));
         send_packet(dir, len, pick_key(), {$urandom, $urandom},
                     dir && ($urandom_range(0, 1) == 1), -1);
      end

      // one longer packet with many full groups
      calm = 1'b0;
      send_packet(FUNC_DECRYPT, LONG_BODY[15:0], {$urandom, $urandom}, 64'd0, 1'b1, -1);

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (board.errors == 0)
         $display("packet_body_xor_checksum_top verification clean");
      else
         $display("packet_body_xor_checksum_top verification failed");
      $finish;
   end

endmodule
